FILE: hdl/i2c_master_byte_engine_assert.svh
// Assertion macros used by the checker file
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define IMBE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset
`define IMBE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/imbe_pkg.sv
package imbe_pkg;

  localparam int unsigned PhW = 5;

  localparam logic [PhW-1:0] PH_IDLE   = 5'd0;
  localparam logic [PhW-1:0] PH_RS_D1  = 5'd1;
  localparam logic [PhW-1:0] PH_RS_W   = 5'd2;
  localparam logic [PhW-1:0] PH_RS_D2  = 5'd3;
  localparam logic [PhW-1:0] PH_ST_CHK = 5'd4;
  localparam logic [PhW-1:0] PH_ST_D   = 5'd5;
  localparam logic [PhW-1:0] PH_WB_D1  = 5'd6;
  localparam logic [PhW-1:0] PH_WB_W   = 5'd7;
  localparam logic [PhW-1:0] PH_WB_D2  = 5'd8;
  localparam logic [PhW-1:0] PH_RB_D1  = 5'd9;
  localparam logic [PhW-1:0] PH_RB_W   = 5'd10;
  localparam logic [PhW-1:0] PH_RB_D2  = 5'd11;
  localparam logic [PhW-1:0] PH_SP_D1  = 5'd12;
  localparam logic [PhW-1:0] PH_SP_W   = 5'd13;
  localparam logic [PhW-1:0] PH_SP_D2  = 5'd14;
  localparam logic [PhW-1:0] PH_SP_CHK = 5'd15;
  localparam logic [PhW-1:0] PH_SP_D3  = 5'd16;

  localparam logic [0:0] REG_HALF_PERIOD   = 1'd0;
  localparam logic [0:0] REG_STRETCH_LIMIT = 1'd1;

  localparam logic [15:0] HALF_PERIOD_RST   = 16'd10;
  localparam logic [15:0] STRETCH_LIMIT_RST = 16'd1000;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_RSVD  = 2'd3
  } op_e;

  // One classified tick, front to back
  typedef struct packed {
    logic       is_write;
    logic       is_read;
    logic [7:0] data_byte;
    logic       start_cond;
    logic       stop_cond;
    logic       ack_to_send;
    logic       clear_lost;
    logic       scl_in;
    logic       sda_in;
  } tick_t;

  // One result item
  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_received;
    logic       lost_flag;
    logic       stretch_timeout;
  } res_t;

  localparam int unsigned QDepth = 2;

endpackage

FILE: hdl/imbe_front.sv
module imbe_front import imbe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic [7:0] data_byte_i,
  input  logic       start_cond_i,
  input  logic       stop_cond_i,
  input  logic       ack_to_send_i,
  input  logic       clear_lost_i,
  input  logic       scl_in_i,
  input  logic       sda_in_i,
  output logic       q_valid_o,
  input  logic       q_pop_i,
  output tick_t      q_data_o
);

  tick_t            mem_q [QDepth];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;
  logic             push;
  tick_t            cls;

  // Classify the op code
  always_comb begin
    cls            = '0;
    cls.data_byte  = data_byte_i;
    cls.start_cond = start_cond_i;
    cls.stop_cond  = stop_cond_i;
    cls.ack_to_send = ack_to_send_i;
    cls.clear_lost = clear_lost_i;
    cls.scl_in     = scl_in_i;
    cls.sda_in     = sda_in_i;
    case (op_e'(op_i))
      OP_WRITE: cls.is_write = 1'b1;
      OP_READ:  cls.is_read  = 1'b1;
      default:  ;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'(QDepth)) && !q_pop_i;
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = cnt_q != 2'd0;
  assign q_data_o   = mem_q[rp_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= cls;
  end

  // Pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

FILE: hdl/imbe_back.sv
module imbe_back import imbe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] half_period_i,
  input  logic [15:0] stretch_limit_i,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  tick_t       q_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output res_t        res_o
);

  logic [PhW-1:0] phase_q, phase_d;
  logic [16:0] dly_q, dly_d;
  logic [15:0] str_q, str_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  sh_q, sh_d;
  logic        bs_q, bs_d, arb_q, arb_d, scl_q, scl_d, sda_q, sda_d;
  logic        f_rd_q, f_rd_d, f_sp_q, f_sp_d, f_nk_q, f_nk_d, f_to_q, f_to_d;
  logic [7:0]  lrd_q, lrd_d;
  logic        lack_q, lack_d, done_d;
  logic        ov_q;
  res_t        res_q;
  logic        step;
  logic [16:0] dinc;
  logic        dover, wover, wflag;

  // Output register frees when taken
  assign step    = q_valid_i && (!ov_q || !out_stall_i);
  assign q_pop_o = step;
  assign out_valid_o = ov_q;
  assign res_o   = res_q;

  assign dinc  = dly_q + 17'd1;
  assign dover = dinc >= {1'b0, (half_period_i == 16'd0) ? 16'd1 : half_period_i};
  assign wflag = !q_data_i.scl_in && (str_q >= stretch_limit_i);
  assign wover = q_data_i.scl_in || wflag;

  // Tick step
  always_comb begin
    logic wr_bit, cbit;
    phase_d = phase_q; dly_d = dly_q; str_d = str_q; bit_d = bit_q; sh_d = sh_q;
    bs_d = bs_q; arb_d = arb_q; scl_d = scl_q; sda_d = sda_q;
    f_rd_d = f_rd_q; f_sp_d = f_sp_q; f_nk_d = f_nk_q; f_to_d = f_to_q;
    lrd_d = lrd_q; lack_d = lack_q; done_d = 1'b0;
    wr_bit = 1'b0; cbit = 1'b0;
    if (q_data_i.clear_lost) arb_d = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (q_data_i.is_write || q_data_i.is_read) begin
          f_rd_d = q_data_i.is_read;
          f_sp_d = q_data_i.stop_cond;
          f_nk_d = q_data_i.is_read && q_data_i.ack_to_send;
          f_to_d = 1'b0;
          sh_d   = q_data_i.is_write ? q_data_i.data_byte : 8'd0;
          bit_d  = 4'd0;
          if (q_data_i.is_write && q_data_i.start_cond) begin
            sda_d = 1'b0;
            if (bs_q) begin phase_d = PH_RS_D1; dly_d = '0; end
            else phase_d = PH_ST_CHK;
          end else begin
            sda_d = q_data_i.is_write ? !q_data_i.data_byte[7] : 1'b0;
            phase_d = q_data_i.is_write ? PH_WB_D1 : PH_RB_D1;
            dly_d = '0;
          end
        end
      end
      PH_RS_D1, PH_WB_D1, PH_RB_D1, PH_SP_D1: begin
        dly_d = dinc;
        if (dover) begin
          phase_d = phase_q + 5'd1; str_d = '0; scl_d = 1'b0;
        end
      end
      PH_RS_W, PH_WB_W, PH_RB_W, PH_SP_W: begin
        if (wflag) f_to_d = 1'b1;
        if (!wover) str_d = str_q + 16'd1;
        else begin
          phase_d = phase_q + 5'd1; dly_d = '0;
          if (phase_q == PH_WB_W) begin
            cbit = f_rd_q ? f_nk_q : sh_q[7];
            if (cbit && !q_data_i.sda_in) arb_d = 1'b1;
          end
          if (phase_q == PH_RB_W) begin
            if (f_rd_q) begin
              sh_d = {sh_q[6:0], q_data_i.sda_in};
              if (bit_q == 4'd7) lrd_d = sh_d;
            end else lack_d = q_data_i.sda_in;
          end
        end
      end
      PH_RS_D2: begin
        dly_d = dinc;
        if (dover) phase_d = PH_ST_CHK;
      end
      PH_ST_CHK: begin
        if (!q_data_i.sda_in) arb_d = 1'b1;
        sda_d = 1'b1; phase_d = PH_ST_D; dly_d = '0;
      end
      PH_ST_D, PH_WB_D2, PH_RB_D2: begin
        dly_d = dinc;
        if (dover) begin
          scl_d = 1'b1;
          if (phase_q == PH_ST_D) begin
            bs_d = 1'b1; bit_d = bit_q;
          end else begin
            if (phase_q == PH_WB_D2 && !f_rd_q) sh_d = {sh_q[6:0], 1'b0};
            bit_d = bit_q + 4'd1;
          end
          if (bit_d < 4'd9) begin
            wr_bit = f_rd_q ? (bit_d >= 4'd8) : (bit_d < 4'd8);
            cbit = f_rd_q ? f_nk_q : sh_d[7];
            sda_d = wr_bit ? !cbit : 1'b0;
            phase_d = wr_bit ? PH_WB_D1 : PH_RB_D1;
            dly_d = '0;
          end else if (f_sp_q) begin
            sda_d = 1'b1; phase_d = PH_SP_D1; dly_d = '0;
          end else begin
            phase_d = PH_IDLE; done_d = 1'b1;
          end
        end
      end
      PH_SP_D2: begin
        dly_d = dinc;
        if (dover) begin sda_d = 1'b0; phase_d = PH_SP_CHK; end
      end
      PH_SP_CHK: begin
        if (!q_data_i.sda_in) arb_d = 1'b1;
        phase_d = PH_SP_D3; dly_d = '0;
      end
      PH_SP_D3: begin
        dly_d = dinc;
        if (dover) begin bs_d = 1'b0; phase_d = PH_IDLE; done_d = 1'b1; end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // Engine state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; dly_q <= '0; str_q <= '0; bit_q <= '0; sh_q <= '0;
      bs_q <= 1'b0; arb_q <= 1'b0; scl_q <= 1'b0; sda_q <= 1'b0;
      f_rd_q <= 1'b0; f_sp_q <= 1'b0; f_nk_q <= 1'b0; f_to_q <= 1'b0;
      lrd_q <= '0; lack_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      if (step) begin
        phase_q <= phase_d; dly_q <= dly_d; str_q <= str_d; bit_q <= bit_d;
        sh_q <= sh_d; bs_q <= bs_d; arb_q <= arb_d; scl_q <= scl_d; sda_q <= sda_d;
        f_rd_q <= f_rd_d; f_sp_q <= f_sp_d; f_nk_q <= f_nk_d; f_to_q <= f_to_d;
        lrd_q <= lrd_d; lack_q <= lack_d;
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q.scl_low         <= scl_d;
      res_q.sda_low         <= sda_d;
      res_q.busy_res        <= phase_d != PH_IDLE;
      res_q.done_res        <= done_d;
      res_q.read_data       <= lrd_d;
      res_q.ack_received    <= lack_d;
      res_q.lost_flag       <= arb_d;
      res_q.stretch_timeout <= f_to_d;
    end
  end

endmodule

FILE: hdl/i2c_master_byte_engine.sv
// I2C master byte engine. Each transfer on the input channel is one bus tick
// carrying sampled SCL/SDA and, when idle, an optional byte write or read
// command; each tick yields exactly one result transfer with the line drives
// and status. One tick is taken per clock unless a stall holds it: a two-entry
// queue feeds the bus sequencer, whose result register is refilled in the
// cycle it is taken. A tick is queued, then registered as a result.
// Registers: 0 half_period (ticks per delay, reset 10), 1 stretch_limit
// (reset 1000); write them only while idle.
module i2c_master_byte_engine import imbe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  data_byte_i,
  input  logic        start_cond_i,
  input  logic        stop_cond_i,
  input  logic        ack_to_send_i,
  input  logic        clear_lost_i,
  input  logic        scl_in_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        scl_low_o,
  output logic        sda_low_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  read_data_o,
  output logic        ack_received_o,
  output logic        lost_flag_o,
  output logic        stretch_timeout_o
);

  logic [15:0] half_q, lim_q;
  logic        qv, pop;
  tick_t       qd;
  res_t        res;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= HALF_PERIOD_RST; lim_q <= STRETCH_LIMIT_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_HALF_PERIOD) half_q <= cfg_wdata_i;
      else lim_q <= cfg_wdata_i;
    end
  end

  imbe_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i, .data_byte_i,
    .start_cond_i, .stop_cond_i, .ack_to_send_i, .clear_lost_i,
    .scl_in_i, .sda_in_i,
    .q_valid_o(qv), .q_pop_i(pop), .q_data_o(qd)
  );

  imbe_back u_back (
    .clk_i, .rst_ni, .half_period_i(half_q), .stretch_limit_i(lim_q),
    .q_valid_i(qv), .q_pop_o(pop), .q_data_i(qd),
    .out_valid_o, .out_stall_i, .res_o(res)
  );

  assign scl_low_o         = res.scl_low;
  assign sda_low_o         = res.sda_low;
  assign busy_res_o        = res.busy_res;
  assign done_res_o        = res.done_res;
  assign read_data_o       = res.read_data;
  assign ack_received_o    = res.ack_received;
  assign lost_flag_o       = res.lost_flag;
  assign stretch_timeout_o = res.stretch_timeout;

endmodule

FILE: hdl/imbe_checker.sv
`include "i2c_master_byte_engine_assert.svh"

module imbe_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic busy_res_o,
  input logic done_res_o,
  input logic lost_flag_o
);

  // Done never coincides with busy
  `IMBE_ASSERT_IMP(a_done_idle, clk_i, rst_ni, out_valid_o && done_res_o, !busy_res_o)
  // Stalled result holds valid
  `IMBE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  // Stalled result holds its lost flag
  `IMBE_ASSERT_NXT(a_lost_hold, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(lost_flag_o))
  // No input stall while output is free
  `IMBE_ASSERT_IMP(a_no_stall, clk_i, rst_ni, !out_valid_o, !in_stall_o)

endmodule

bind i2c_master_byte_engine imbe_checker u_imbe_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i,
  .busy_res_o, .done_res_o, .lost_flag_o
);

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import imbe_pkg::*;

  localparam int unsigned CycleLimit = 300000;

  // idling modes
  localparam int unsigned IdleNone = 0;
  localparam int unsigned IdleSend = 1;
  localparam int unsigned IdleRecv = 2;
  localparam int unsigned IdleBoth = 3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i = OP_TICK;
  logic [7:0]  data_byte_i = '0;
  logic        start_cond_i = 1'b0;
  logic        stop_cond_i = 1'b0;
  logic        ack_to_send_i = 1'b0;
  logic        clear_lost_i = 1'b0;
  logic        scl_in_i = 1'b1;
  logic        sda_in_i = 1'b1;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        scl_low_o, sda_low_o, busy_res_o, done_res_o;
  logic [7:0]  read_data_o;
  logic        ack_received_o, lost_flag_o, stretch_timeout_o;

  i2c_master_byte_engine dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Bus engine predictor
  // ---------------------------------------------------------------------
  localparam logic [3:0] FlagRead = 4'd1;
  localparam logic [3:0] FlagStop = 4'd2;
  localparam logic [3:0] FlagNack = 4'd4;
  localparam logic [3:0] FlagTmo  = 4'd8;

  logic [15:0]    half_ticks, stretch_max;
  logic [PhW-1:0] eng_phase;
  logic [16:0]    delay_ctr;
  logic [15:0]    stretch_ctr;
  logic [3:0]     bit_pos, flags;
  logic [7:0]     shifter, last_rd_byte;
  logic           bus_busy_line, arb_lost, pull_scl, pull_sda, last_ack, done_tick;

  function automatic void model_reset();
    half_ticks = HALF_PERIOD_RST; stretch_max = STRETCH_LIMIT_RST;
    eng_phase = PH_IDLE; delay_ctr = '0; stretch_ctr = '0; bit_pos = '0;
    shifter = '0; bus_busy_line = 1'b0; arb_lost = 1'b0; pull_scl = 1'b0;
    pull_sda = 1'b0; flags = '0; last_rd_byte = '0; last_ack = 1'b0;
    done_tick = 1'b0;
  endfunction

  function automatic void start_delay(logic [PhW-1:0] p);
    eng_phase = p; delay_ctr = '0;
  endfunction

  function automatic void start_wait(logic [PhW-1:0] p);
    eng_phase = p; stretch_ctr = '0; pull_scl = 1'b0;
  endfunction

  function automatic logic delay_done();
    delay_ctr = delay_ctr + 17'd1;
    return delay_ctr >= {1'b0, half_ticks};
  endfunction

  function automatic logic scl_seen(logic scl);
    if (scl) return 1'b1;
    if (stretch_ctr >= stretch_max) begin
      flags |= FlagTmo;
      return 1'b1;
    end
    stretch_ctr++;
    return 1'b0;
  endfunction

  function automatic logic master_drives_bit();
    if (flags & FlagRead) return bit_pos >= 4'd8;
    return bit_pos < 4'd8;
  endfunction

  function automatic logic out_bit();
    if (flags & FlagRead) return (flags & FlagNack) != 0;
    return shifter[7];
  endfunction

  function automatic void bit_begin();
    if (master_drives_bit()) begin
      pull_sda = !out_bit();
      start_delay(PH_WB_D1);
    end else begin
      pull_sda = 1'b0;
      start_delay(PH_RB_D1);
    end
  endfunction

  function automatic void bit_advance();
    bit_pos = bit_pos + 4'd1;
    if (bit_pos < 4'd9) begin
      bit_begin();
    end else if (flags & FlagStop) begin
      pull_sda = 1'b1;
      start_delay(PH_SP_D1);
    end else begin
      eng_phase = PH_IDLE;
      done_tick = 1'b1;
    end
  endfunction

  function automatic res_t engine_tick(logic [1:0] op, logic [7:0] data, logic start,
                                       logic stop, logic ack, logic clr, logic scl,
                                       logic sda);
    res_t r;
    done_tick = 1'b0;
    if (clr) arb_lost = 1'b0;
    case (eng_phase)
      PH_IDLE: begin
        if (op == OP_WRITE) begin
          flags = stop ? FlagStop : 4'd0;
          shifter = data;
          bit_pos = '0;
          if (start) begin
            pull_sda = 1'b0;
            if (bus_busy_line) start_delay(PH_RS_D1);
            else eng_phase = PH_ST_CHK;
          end else begin
            bit_begin();
          end
        end else if (op == OP_READ) begin
          flags = FlagRead | (stop ? FlagStop : 4'd0) | (ack ? FlagNack : 4'd0);
          shifter = '0;
          bit_pos = '0;
          bit_begin();
        end
      end
      PH_RS_D1: if (delay_done()) start_wait(PH_RS_W);
      PH_RS_W: if (scl_seen(scl)) start_delay(PH_RS_D2);
      PH_RS_D2: if (delay_done()) eng_phase = PH_ST_CHK;
      PH_ST_CHK: begin
        if (!sda) arb_lost = 1'b1;
        pull_sda = 1'b1;
        start_delay(PH_ST_D);
      end
      PH_ST_D: begin
        if (delay_done()) begin
          pull_scl = 1'b1; bus_busy_line = 1'b1; bit_begin();
        end
      end
      PH_WB_D1: if (delay_done()) start_wait(PH_WB_W);
      PH_WB_W: begin
        if (scl_seen(scl)) begin
          if (out_bit() && !sda) arb_lost = 1'b1;
          start_delay(PH_WB_D2);
        end
      end
      PH_WB_D2: begin
        if (delay_done()) begin
          pull_scl = 1'b1;
          if (!(flags & FlagRead)) shifter = shifter << 1;
          bit_advance();
        end
      end
      PH_RB_D1: if (delay_done()) start_wait(PH_RB_W);
      PH_RB_W: begin
        if (scl_seen(scl)) begin
          if (flags & FlagRead) begin
            shifter = {shifter[6:0], sda};
            if (bit_pos == 4'd7) last_rd_byte = shifter;
          end else begin
            last_ack = sda;
          end
          start_delay(PH_RB_D2);
        end
      end
      PH_RB_D2: begin
        if (delay_done()) begin
          pull_scl = 1'b1; bit_advance();
        end
      end
      PH_SP_D1: if (delay_done()) start_wait(PH_SP_W);
      PH_SP_W: if (scl_seen(scl)) start_delay(PH_SP_D2);
      PH_SP_D2: begin
        if (delay_done()) begin
          pull_sda = 1'b0; eng_phase = PH_SP_CHK;
        end
      end
      PH_SP_CHK: begin
        if (!sda) arb_lost = 1'b1;
        start_delay(PH_SP_D3);
      end
      PH_SP_D3: begin
        if (delay_done()) begin
          bus_busy_line = 1'b0; eng_phase = PH_IDLE; done_tick = 1'b1;
        end
      end
      default: eng_phase = PH_IDLE;
    endcase
    r.scl_low = pull_scl;
    r.sda_low = pull_sda;
    r.busy_res = eng_phase != PH_IDLE;
    r.done_res = done_tick;
    r.read_data = last_rd_byte;
    r.ack_received = last_ack;
    r.lost_flag = arb_lost;
    r.stretch_timeout = (flags & FlagTmo) != 0;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------
  res_t pending_res[$];
  bit   failed = 1'b0;

  function automatic void check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_res.size() == 0) begin
        $error("result transfer with no expectation pending");
        failed = 1'b1;
      end else begin
        e = pending_res.pop_front();
        check_field("scl_low", e.scl_low, scl_low_o);
        check_field("sda_low", e.sda_low, sda_low_o);
        check_field("busy_res", e.busy_res, busy_res_o);
        check_field("done_res", e.done_res, done_res_o);
        check_field("read_data", e.read_data, read_data_o);
        check_field("ack_received", e.ack_received, ack_received_o);
        check_field("lost_flag", e.lost_flag, lost_flag_o);
        check_field("stretch_timeout", e.stretch_timeout, stretch_timeout_o);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver stall, with a long hold-off on request
  // ---------------------------------------------------------------------
  int unsigned idle_mode = IdleNone;
  bit          holdoff_req = 1'b0;
  int unsigned holdoff_left = 0;

  // idle share in percent for the current mode
  function automatic int unsigned idle_pct();
    return (idle_mode == IdleBoth) ? 12 : 82;
  endfunction

  always @(posedge clk_i) begin
    if (holdoff_req && holdoff_left == 0) holdoff_left <= 80;
    if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (idle_mode == IdleRecv || idle_mode == IdleBoth) &&
                     $urandom_range(99) < idle_pct();
    end
  end

  // cycle limit
  int unsigned cycle_ctr = 0;
  always @(posedge clk_i) begin
    cycle_ctr <= cycle_ctr + 1;
    if (cycle_ctr > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  // one input transfer; expectation from the predictor unless given
  task automatic send_tick(logic [1:0] op, logic [7:0] data, logic start, logic stop,
                           logic ack, logic clr, logic scl, logic sda,
                           bit use_given, res_t given);
    res_t r;
    if ((idle_mode == IdleSend || idle_mode == IdleBoth) &&
        $urandom_range(99) < idle_pct()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct()) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op; data_byte_i <= data; start_cond_i <= start; stop_cond_i <= stop;
    ack_to_send_i <= ack; clear_lost_i <= clr; scl_in_i <= scl; sda_in_i <= sda;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = engine_tick(op, data, start, stop, ack, clr, scl, sda);
    pending_res.push_back(use_given ? given : r);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_HALF_PERIOD) half_ticks = val;
    else stretch_max = val;
  endtask

  // finish the running command, then let every result drain
  task automatic settle();
    res_t none;
    none = '0;
    while (eng_phase != PH_IDLE)
      send_tick(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, none);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // random ticks that follow the line drives, with clock stretching
  int unsigned stretch_run = 0;
  task automatic random_ticks(int unsigned n, bit cmds);
    logic [1:0] op;
    logic       scl, sda;
    res_t       none;
    none = '0;
    repeat (n) begin
      op = OP_TICK;
      if (cmds) begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5, 6: op = OP_WRITE;
          7, 8, 9, 10, 11, 12, 13: op = OP_READ;
          14, 15: op = OP_RSVD;
          default: op = OP_TICK;
        endcase
      end
      if (stretch_run == 0 && $urandom_range(19) == 0) stretch_run = $urandom_range(1, 8);
      if (stretch_run != 0) begin
        scl = 1'b0;
        stretch_run--;
      end else begin
        scl = !pull_scl;
      end
      sda = pull_sda ? 1'b0 : ($urandom_range(3) != 0);
      send_tick(op, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                $urandom_range(7) == 0, scl, sda, 1'b0, none);
    end
  endtask

  typedef struct {
    logic [1:0] op;
    logic [7:0] data;
    logic       start, stop, ack, clr, scl, sda;
    bit         given;
    res_t       exp;
  } stim_row_t;

  stim_row_t dir_rows[$];

  initial begin
    res_t zero_res;
    zero_res = '0;
    // after reset: released lines, nothing pending
    dir_rows.push_back('{OP_TICK, 8'h00, 0, 0, 0, 0, 1, 1, 1, zero_res});
    // reserved op acts as a plain tick
    dir_rows.push_back('{OP_RSVD, 8'hFF, 1, 1, 1, 1, 1, 1, 1, zero_res});
    // write with start and stop, all ones; then commands while busy
    dir_rows.push_back('{OP_WRITE, 8'hFF, 1, 1, 0, 0, 1, 1, 0, zero_res});
    dir_rows.push_back('{OP_READ, 8'h00, 0, 0, 1, 0, 1, 0, 0, zero_res});
    dir_rows.push_back('{OP_WRITE, 8'h00, 1, 0, 0, 1, 1, 0, 0, zero_res});
    dir_rows.push_back('{OP_TICK, 8'h00, 0, 0, 0, 1, 0, 1, 0, zero_res});
    repeat (14) dir_rows.push_back('{OP_TICK, 8'h00, 0, 0, 0, 0, 1, 1, 0, zero_res});

    model_reset();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // phase 0: reset config, directed then random, with a long receiver hold-off
    idle_mode = IdleNone;
    foreach (dir_rows[i])
      send_tick(dir_rows[i].op, dir_rows[i].data, dir_rows[i].start, dir_rows[i].stop,
                dir_rows[i].ack, dir_rows[i].clr, dir_rows[i].scl, dir_rows[i].sda,
                dir_rows[i].given, dir_rows[i].exp);
    holdoff_req = 1'b1;
    random_ticks(40, 1'b1);
    holdoff_req = 1'b0;
    random_ticks(140, 1'b1);
    settle();

    // phase 1: fastest clock, no stretch tolerance
    write_reg(REG_HALF_PERIOD, 16'd1);
    write_reg(REG_STRETCH_LIMIT, 16'd0);
    idle_mode = IdleSend;
    random_ticks(200, 1'b1);
    settle();

    // phase 2: half period of zero counts as one
    write_reg(REG_HALF_PERIOD, 16'd0);
    write_reg(REG_STRETCH_LIMIT, 16'd3);
    idle_mode = IdleRecv;
    random_ticks(200, 1'b1);
    settle();

    // phase 3: widest stretch tolerance
    write_reg(REG_HALF_PERIOD, 16'd2);
    write_reg(REG_STRETCH_LIMIT, 16'hFFFF);
    idle_mode = IdleBoth;
    random_ticks(200, 1'b1);
    settle();

    // phase 4: slowest clock, ticks only
    write_reg(REG_HALF_PERIOD, 16'hFFFF);
    write_reg(REG_STRETCH_LIMIT, 16'd1);
    idle_mode = IdleNone;
    random_ticks(30, 1'b0);
    settle();

    if (failed || pending_res.size() != 0) begin
      if (pending_res.size() != 0) $error("%0d results never arrived", pending_res.size());
      $display("tb: failure");
    end else begin
      $display("tb: success");
    end
    $finish;
  end

endmodule
